>>> sv/assert_macros.svh
// Assertion macros used by the top level of the rotate-half pair block.
// Define ASSERT_OFF to compile the design without any checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> sv/rerp_pkg.sv
// Shared types and constants of the rotary embedding pair rotate block.
// No dependencies; imported by the lane and the top level.
`timescale 1ns / 1ps
package rerp_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // Rotation direction register codes.
  localparam logic DIR_FORWARD  = 1'b0;
  localparam logic DIR_BACKWARD = 1'b1;

  // Per-lane control carried alongside the operands.
  typedef struct packed {
    logic sub;   // second product is subtracted
    logic copy;  // pass the first operand through unchanged
  } lane_ctrl_t;

endpackage

>>> sv/rerp_lane.sv
// One rotation lane: a*b +/- c*d, arithmetic shift and saturation.
// Depends on rerp_pkg for the lane control struct.
`timescale 1ns / 1ps
module rerp_lane #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    a_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  b_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    c_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  d_i,
  input  rerp_pkg::lane_ctrl_t              ctrl_i,
  output logic signed [SAMPLE_WIDTH-1:0]    y_o,
  output logic                              hit_o
);
  import rerp_pkg::*;

  localparam int TW   = TRIG_FRAC_BITS + 2;
  localparam int PW   = SAMPLE_WIDTH + TW;
  localparam int SUMW = PW + 1;

  localparam logic signed [SUMW-1:0] YMAX =
    {{(SUMW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] YMIN =
    {{(SUMW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]           prod_ab_d, prod_ab_q;
  logic signed [PW-1:0]           prod_cd_d, prod_cd_q;
  logic signed [SAMPLE_WIDTH-1:0] pass_q;
  lane_ctrl_t                     ctrl_q;
  logic signed [SUMW-1:0]         sum;
  logic signed [SUMW-1:0]         scaled;

  assign prod_ab_d = PW'(a_i) * PW'(b_i);
  assign prod_cd_d = PW'(c_i) * PW'(d_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_ab_q <= prod_ab_d;
      prod_cd_q <= prod_cd_d;
      pass_q    <= a_i;
      ctrl_q    <= ctrl_i;
    end
  end

  // The exact sum is floored by the arithmetic shift, then clamped.
  always_comb begin
    if (ctrl_q.sub) begin
      sum = SUMW'(prod_ab_q) - SUMW'(prod_cd_q);
    end else begin
      sum = SUMW'(prod_ab_q) + SUMW'(prod_cd_q);
    end
    scaled = sum >>> TRIG_FRAC_BITS;
    hit_o  = 1'b0;
    if (ctrl_q.copy) begin
      y_o = pass_q;
    end else if (scaled > YMAX) begin
      y_o   = YMAX[SAMPLE_WIDTH-1:0];
      hit_o = 1'b1;
    end else if (scaled < YMIN) begin
      y_o   = YMIN[SAMPLE_WIDTH-1:0];
      hit_o = 1'b1;
    end else begin
      y_o = scaled[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

>>> sv/rerp_merge.sv
// Merging stage: joins the two lane results into one output beat.
// Holds the output register; no package dependency.
`timescale 1ns / 1ps
module rerp_merge #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int OUT_W        = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [SAMPLE_WIDTH-1:0]  y_lo_i,
  input  logic [SAMPLE_WIDTH-1:0]  y_hi_i,
  input  logic                     hit_lo_i,
  input  logic                     hit_hi_i,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_W-1:0]         m_axis_tdata,
  output logic [0:0]               m_axis_tuser
);

  logic             valid_q;
  logic [OUT_W-1:0] data_d, data_q;
  logic             clip_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    data_d = '0;
    data_d[SAMPLE_WIDTH-1:0]              = y_lo_i;
    data_d[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] = y_hi_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      clip_q <= hit_lo_i | hit_hi_i;
    end
  end

  assign m_axis_tvalid   = valid_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = clip_q;

endmodule

>>> sv/rotary_embedding_pair_rotate.sv
// Top level of the rotary embedding rotate-half pair block.
// Depends on rerp_pkg, rerp_lane, rerp_merge and assert_macros.svh.
`timescale 1ns / 1ps
// Rotates one rotate-half pair per beat: y_lo = x_lo*cos_lo -/+ x_hi*sin, y_hi = x_hi*cos_hi
// +/- x_lo*sin, floored by the Q1.TRIG_FRAC_BITS scale and saturated to SAMPLE_WIDTH bits,
// with tuser[0] of the result flagging saturation. The direction register (bit 0 of cfg_data_i)
// selects forward (0) or transposed backward (1) rotation; write it only while the block is idle.
// Input tuser[0] set copies x_lo and x_hi through unchanged. The block takes one beat per cycle
// unless the output stalls. The lane products are registered when an input beat is accepted,
// and the add, shift and saturate path then loads the output register, which offers the result
// beat. The input is held off only while both register stages are full and the output beat
// is not taken.
module rotary_embedding_pair_rotate #(
  parameter int SAMPLE_WIDTH   = rerp_pkg::SAMPLE_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = rerp_pkg::TRIG_FRAC_BITS_DEF,
  localparam int TW    = TRIG_FRAC_BITS + 2,
  localparam int IN_W  = ((2*SAMPLE_WIDTH + 4*TW + 7) / 8) * 8,
  localparam int OUT_W = ((2*SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,     // direction
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // x_lo, x_hi, cos_lo, cos_hi, sin_lo, sin_hi
  input  logic [0:0]        s_axis_tuser,   // copy_through
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // y_lo, y_hi
  output logic [0:0]        m_axis_tuser    // clipped
);
  import rerp_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic                 direction_q;
  logic                 v1_q;
  logic                 en1;
  logic                 ready2;
  logic signed [SW-1:0] x_lo, x_hi;
  logic signed [TW-1:0] cos_lo, cos_hi, sin_lo, sin_hi;
  lane_ctrl_t           ctrl_lo, ctrl_hi;
  logic signed [SW-1:0] y_lo, y_hi;
  logic                 hit_lo, hit_hi;
  logic [SW-1:0]        out_lo, out_hi;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_FORWARD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      direction_q <= cfg_data_i;
    end
  end

  assign x_lo   = s_axis_tdata[SW-1:0];
  assign x_hi   = s_axis_tdata[2*SW-1:SW];
  assign cos_lo = s_axis_tdata[2*SW+TW-1:2*SW];
  assign cos_hi = s_axis_tdata[2*SW+2*TW-1:2*SW+TW];
  assign sin_lo = s_axis_tdata[2*SW+3*TW-1:2*SW+2*TW];
  assign sin_hi = s_axis_tdata[2*SW+4*TW-1:2*SW+3*TW];

  // Forward subtracts in the low lane, backward in the high lane.
  assign ctrl_lo.sub  = (direction_q == DIR_FORWARD);
  assign ctrl_lo.copy = s_axis_tuser[0];
  assign ctrl_hi.sub  = (direction_q == DIR_BACKWARD);
  assign ctrl_hi.copy = s_axis_tuser[0];

  assign en1           = !v1_q || ready2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  rerp_lane #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_lo (
    .clk_i  (clk_i),
    .en_i   (en1 && s_axis_tvalid),
    .a_i    (x_lo),
    .b_i    (cos_lo),
    .c_i    (x_hi),
    .d_i    ((direction_q == DIR_BACKWARD) ? sin_hi : sin_lo),
    .ctrl_i (ctrl_lo),
    .y_o    (y_lo),
    .hit_o  (hit_lo)
  );

  rerp_lane #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_hi (
    .clk_i  (clk_i),
    .en_i   (en1 && s_axis_tvalid),
    .a_i    (x_hi),
    .b_i    (cos_hi),
    .c_i    (x_lo),
    .d_i    ((direction_q == DIR_BACKWARD) ? sin_lo : sin_hi),
    .ctrl_i (ctrl_hi),
    .y_o    (y_hi),
    .hit_o  (hit_hi)
  );

  assign out_lo = y_lo;
  assign out_hi = y_hi;

  rerp_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .OUT_W        (OUT_W)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v1_q),
    .ready_o       (ready2),
    .y_lo_i        (out_lo),
    .y_hi_i        (out_hi),
    .hit_lo_i      (hit_lo),
    .hit_hi_i      (hit_hi),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`include "assert_macros.svh"

  // Input is held off only when both pipeline stages are full and the output stalls.
  `ASSERT_IMPL(a_ready_only_when_full, clk_i, rst_ni, !s_axis_tready, v1_q && m_axis_tvalid && !m_axis_tready, "input stalled without a full pipeline")
  // A lane result that cannot move on stays in the first stage.
  `ASSERT_NEXT(a_stage1_held, clk_i, rst_ni, v1_q && !ready2, v1_q, "stage one result dropped")
  // A clipped result must sit on one of the saturation limits.
  `ASSERT_IMPL(a_clip_at_limit, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[SW-1:0] == {1'b0, {(SW-1){1'b1}}}) || (m_axis_tdata[SW-1:0] == {1'b1, {(SW-1){1'b0}}}) || (m_axis_tdata[2*SW-1:SW] == {1'b0, {(SW-1){1'b1}}}) || (m_axis_tdata[2*SW-1:SW] == {1'b1, {(SW-1){1'b0}}}), "clipped flag without a limit value")

endmodule
